/* src/tpcs_pkg.sv */
// Shared types and widths for the three point curve sampler.
// No dependencies; the design modules use it by scoped names.
package tpcs_pkg;

  localparam int CW   = 12;  // coordinate
  localparam int DW   = 13;  // signed coordinate difference
  localparam int IW   = 6;   // sample number
  localparam int YW   = 16;  // output y
  localparam int PW   = 26;  // product of two differences
  localparam int CFW  = 25;  // y times a difference
  localparam int TW   = 51;  // one Lagrange term
  localparam int NW   = 53;  // numerator
  localparam int NMW  = 52;  // numerator magnitude
  localparam int DENW = 39;  // denominator
  localparam int DMW  = 38;  // denominator magnitude
  localparam int QW   = 17;  // quotient bits kept before saturation
  localparam int RW   = DMW + QW;

  typedef struct packed {
    logic [CW-1:0]          sx;
    logic [CW-1:0]          sy;
    logic [CW-1:0]          mx;
    logic [CW-1:0]          tx;
    logic [CW-1:0]          ty;
    logic signed [CFW-1:0]  c1;
    logic signed [CFW-1:0]  c2;
    logic signed [CFW-1:0]  c3;
    logic signed [DENW-1:0] den;
    logic signed [DW-1:0]   step;
    logic                   degen;
  } item_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [CW-1:0] x;
    logic [YW-1:0] fix_y;
    logic          fixed;
    logic          degen;
    logic          last;
  } meta_t;

  typedef struct packed {
    meta_t                  m;
    logic [CW-1:0]          sx;
    logic [CW-1:0]          mx;
    logic [CW-1:0]          tx;
    logic signed [CFW-1:0]  c1;
    logic signed [CFW-1:0]  c2;
    logic signed [CFW-1:0]  c3;
    logic signed [DENW-1:0] den;
  } samp_t;

endpackage

/* src/three_point_curve_sampler_top.sv */
// Three point curve sampler: samples the parabola through start, middle
// and target points. Depends on tpcs_pkg and the tpcs_* modules.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word of three 12-bit points.
//   Result channel (out_valid/out_ready) returns NUM_POINTS words for it:
//   sample 0 is the start point, sample NUM_POINTS-1 the target point, and
//   the interior samples step evenly in x with y on the parabola, truncated
//   toward zero and saturated to 16-bit signed. If two x coordinates match,
//   interior samples carry degenerate = 1 and y = 0.
// Throughput: one result word a cycle while the output is not held by
//   out_ready; the sequencer walks the samples. Up to two further words
//   wait in the two setup stages, so the next word is taken while results
//   of the current one are still in flight.
// Path: from the accepting edge a word passes the second setup stage,
//   the sequencer register, three numerator stages, a prep stage, 17
//   divider stages (one quotient bit each) and the output register to out_valid.
// Reset: synchronous, active low; drops all words in flight.
// Stall: when out_valid is high and out_ready low the sample pipeline holds;
//   nothing is lost or repeated, and in_ready falls once the setup stages fill.
module three_point_curve_sampler_top #(
  parameter int NUM_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_start_x,
  input  logic [11:0] in_start_y,
  input  logic [11:0] in_mid_x,
  input  logic [11:0] in_mid_y,
  input  logic [11:0] in_target_x,
  input  logic [11:0] in_target_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_point_index,
  output logic [11:0] out_point_x,
  output logic [15:0] out_point_y,
  output logic        out_degenerate,
  output logic        out_last_point
);
  logic                             en;
  logic                             b_valid, b_take;
  tpcs_pkg::item_t                  b_item;
  logic                             s_valid;
  tpcs_pkg::samp_t                  s_samp;
  logic                             n_valid;
  tpcs_pkg::meta_t                  n_meta;
  logic signed [tpcs_pkg::NW-1:0]   n_num;
  logic signed [tpcs_pkg::DENW-1:0] n_den;
  tpcs_pkg::meta_t                  o_meta;
  logic [tpcs_pkg::YW-1:0]          o_y;

  // advance the sample pipeline unless the output word is held
  assign en = !out_valid || out_ready;

  tpcs_setup #(.NUM_POINTS(NUM_POINTS)) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .mid_x    (in_mid_x),
    .mid_y    (in_mid_y),
    .target_x (in_target_x),
    .target_y (in_target_y),
    .b_take   (b_take),
    .b_valid  (b_valid),
    .b_item   (b_item)
  );

  tpcs_seq #(.NUM_POINTS(NUM_POINTS)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .b_valid (b_valid),
    .b_item  (b_item),
    .b_take  (b_take),
    .s_valid (s_valid),
    .s_samp  (s_samp)
  );

  tpcs_num u_num (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s_valid (s_valid),
    .s_samp  (s_samp),
    .n_valid (n_valid),
    .n_meta  (n_meta),
    .n_num   (n_num),
    .n_den   (n_den)
  );

  tpcs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .n_valid (n_valid),
    .n_meta  (n_meta),
    .n_num   (n_num),
    .n_den   (n_den),
    .o_valid (out_valid),
    .o_meta  (o_meta),
    .o_y     (o_y)
  );

  assign out_point_index = o_meta.idx;
  assign out_point_x     = o_meta.x;
  assign out_point_y     = o_y;
  assign out_degenerate  = o_meta.degen;
  assign out_last_point  = o_meta.last;
endmodule

/* src/tpcs_setup.sv */
// Per-word setup: differences, coefficients, denominator and x step.
// Two register stages. Depends on tpcs_pkg.
module tpcs_setup #(
  parameter int NUM_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        start_x,
  input  logic [11:0]        start_y,
  input  logic [11:0]        mid_x,
  input  logic [11:0]        mid_y,
  input  logic [11:0]        target_x,
  input  logic [11:0]        target_y,
  input  logic               b_take,
  output logic               b_valid,
  output tpcs_pkg::item_t    b_item
);
  localparam int DIV   = NUM_POINTS - 1;
  localparam int SH    = 24;
  localparam int RECW  = 25;
  localparam int SPW   = tpcs_pkg::CW + RECW;
  localparam logic [RECW-1:0] RECIP = RECW'((2**SH + DIV - 1) / DIV);

  logic                             a_v_r, b_v_r;
  logic [tpcs_pkg::CW-1:0]          a_sx_r, a_sy_r, a_mx_r, a_tx_r, a_ty_r;
  logic signed [tpcs_pkg::DW-1:0]   a_d23_r;
  logic signed [tpcs_pkg::PW-1:0]   a_p12_r;
  logic signed [tpcs_pkg::CFW-1:0]  a_c1_r, a_c2_r, a_c3_r;
  logic [SPW-1:0]                   a_sp_r;
  logic                             a_sneg_r, a_degen_r;
  tpcs_pkg::item_t                  b_item_r;

  logic signed [tpcs_pkg::DW-1:0]   d12, d13, d23;
  logic [tpcs_pkg::CW-1:0]          span;
  logic [tpcs_pkg::CW-1:0]          smag;
  logic                             a_move, a_load;

  always_comb begin
    d12  = $signed({1'b0, start_x}) - $signed({1'b0, mid_x});
    d13  = $signed({1'b0, start_x}) - $signed({1'b0, target_x});
    d23  = $signed({1'b0, mid_x}) - $signed({1'b0, target_x});
    span = d13[tpcs_pkg::DW-1] ? tpcs_pkg::CW'(-d13) : d13[tpcs_pkg::CW-1:0];
    smag = a_sp_r[SH +: tpcs_pkg::CW];
  end

  assign a_move   = a_v_r && (!b_v_r || b_take);
  assign in_ready = !a_v_r || a_move;
  assign a_load   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (in_ready) a_v_r <= in_valid;
      if (!b_v_r || b_take) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_sx_r    <= start_x;
      a_sy_r    <= start_y;
      a_mx_r    <= mid_x;
      a_tx_r    <= target_x;
      a_ty_r    <= target_y;
      a_d23_r   <= d23;
      a_p12_r   <= tpcs_pkg::PW'(d12 * d13);
      a_c1_r    <= tpcs_pkg::CFW'($signed({1'b0, start_y}) * d23);
      a_c2_r    <= tpcs_pkg::CFW'($signed({1'b0, mid_y}) * d13);
      a_c3_r    <= tpcs_pkg::CFW'($signed({1'b0, target_y}) * d12);
      a_sp_r    <= SPW'(span) * SPW'(RECIP);
      a_sneg_r  <= ~d13[tpcs_pkg::DW-1] & (d13 != '0);  // target left of start
      a_degen_r <= (start_x == mid_x) || (start_x == target_x) || (mid_x == target_x);
    end
    if (a_move) begin
      b_item_r.sx    <= a_sx_r;
      b_item_r.sy    <= a_sy_r;
      b_item_r.mx    <= a_mx_r;
      b_item_r.tx    <= a_tx_r;
      b_item_r.ty    <= a_ty_r;
      b_item_r.c1    <= a_c1_r;
      b_item_r.c2    <= a_c2_r;
      b_item_r.c3    <= a_c3_r;
      b_item_r.den   <= tpcs_pkg::DENW'(a_p12_r * a_d23_r);
      b_item_r.step  <= a_sneg_r ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
      b_item_r.degen <= a_degen_r;
    end
  end

  assign b_valid = b_v_r;
  assign b_item  = b_item_r;
endmodule

/* src/tpcs_seq.sv */
// Sample sequencer: walks one word's samples, one per enabled cycle.
// Depends on tpcs_pkg.
module tpcs_seq #(
  parameter int NUM_POINTS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             b_valid,
  input  tpcs_pkg::item_t  b_item,
  output logic             b_take,
  output logic             s_valid,
  output tpcs_pkg::samp_t  s_samp
);
  localparam logic [tpcs_pkg::IW-1:0] LAST = tpcs_pkg::IW'(NUM_POINTS - 1);

  logic                    busy_r;
  tpcs_pkg::item_t         cur_r;
  logic [tpcs_pkg::IW-1:0] idx_r;
  logic [tpcs_pkg::CW-1:0] x_r;
  logic                    is_last, is_first;

  assign is_last  = (idx_r == LAST);
  assign is_first = (idx_r == '0);
  assign b_take   = b_valid && (!busy_r || (en && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (b_take) begin
      busy_r <= 1'b1;
    end else if (en && busy_r && is_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      cur_r <= b_item;
      idx_r <= '0;
      x_r   <= b_item.sx;
    end else if (en && busy_r) begin
      idx_r <= idx_r + 1'b1;
      x_r   <= tpcs_pkg::CW'($signed({1'b0, x_r}) + cur_r.step);
    end
  end

  always_comb begin
    s_samp.m.idx   = idx_r;
    s_samp.m.x     = is_last ? cur_r.tx : x_r;
    s_samp.m.fixed = is_first || is_last;
    s_samp.m.fix_y = {4'b0, is_first ? cur_r.sy : cur_r.ty};
    s_samp.m.degen = cur_r.degen && !(is_first || is_last);
    s_samp.m.last  = is_last;
    s_samp.sx      = cur_r.sx;
    s_samp.mx      = cur_r.mx;
    s_samp.tx      = cur_r.tx;
    s_samp.c1      = cur_r.c1;
    s_samp.c2      = cur_r.c2;
    s_samp.c3      = cur_r.c3;
    s_samp.den     = cur_r.den;
  end

  assign s_valid = busy_r;
endmodule

/* src/tpcs_num.sv */
// Lagrange numerator: pair products, terms, sum. Three register stages.
// Depends on tpcs_pkg.
module tpcs_num (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           s_valid,
  input  tpcs_pkg::samp_t                s_samp,
  output logic                           n_valid,
  output tpcs_pkg::meta_t                n_meta,
  output logic signed [tpcs_pkg::NW-1:0]   n_num,
  output logic signed [tpcs_pkg::DENW-1:0] n_den
);
  logic                               v1_r, v2_r, v3_r;
  tpcs_pkg::meta_t                    m1_r, m2_r, m3_r;
  logic signed [tpcs_pkg::DENW-1:0]   den1_r, den2_r, den3_r;
  logic signed [tpcs_pkg::CFW-1:0]    c1_r, c2_r, c3_r;
  logic signed [tpcs_pkg::PW-1:0]     ab_r, ac_r, bc_r;
  logic signed [tpcs_pkg::TW-1:0]     t1_r, t2_r, t3_r;
  logic signed [tpcs_pkg::NW-1:0]     num_r;
  logic signed [tpcs_pkg::DW-1:0]     a, b, c;

  always_comb begin
    a = $signed({1'b0, s_samp.m.x}) - $signed({1'b0, s_samp.sx});
    b = $signed({1'b0, s_samp.m.x}) - $signed({1'b0, s_samp.mx});
    c = $signed({1'b0, s_samp.m.x}) - $signed({1'b0, s_samp.tx});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= s_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= s_samp.m;
      den1_r <= s_samp.den;
      c1_r   <= s_samp.c1;
      c2_r   <= s_samp.c2;
      c3_r   <= s_samp.c3;
      ab_r   <= tpcs_pkg::PW'(a * b);
      ac_r   <= tpcs_pkg::PW'(a * c);
      bc_r   <= tpcs_pkg::PW'(b * c);
      m2_r   <= m1_r;
      den2_r <= den1_r;
      t1_r   <= tpcs_pkg::TW'(c1_r * bc_r);
      t2_r   <= tpcs_pkg::TW'(c2_r * ac_r);
      t3_r   <= tpcs_pkg::TW'(c3_r * ab_r);
      m3_r   <= m2_r;
      den3_r <= den2_r;
      num_r  <= tpcs_pkg::NW'(t1_r) - tpcs_pkg::NW'(t2_r) + tpcs_pkg::NW'(t3_r);
    end
  end

  assign n_valid = v3_r;
  assign n_meta  = m3_r;
  assign n_num   = num_r;
  assign n_den   = den3_r;
endmodule

/* src/tpcs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, then
// saturation and the output register. Depends on tpcs_pkg.
module tpcs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             n_valid,
  input  tpcs_pkg::meta_t                  n_meta,
  input  logic signed [tpcs_pkg::NW-1:0]   n_num,
  input  logic signed [tpcs_pkg::DENW-1:0] n_den,
  output logic                             o_valid,
  output tpcs_pkg::meta_t                  o_meta,
  output logic [tpcs_pkg::YW-1:0]          o_y
);
  localparam int QW = tpcs_pkg::QW;

  logic                      v_r    [0:QW];
  tpcs_pkg::meta_t           m_r    [0:QW];
  logic [tpcs_pkg::NMW-1:0]  rem_r  [0:QW];
  logic [tpcs_pkg::DMW-1:0]  dm_r   [0:QW];
  logic [QW-1:0]             q_r    [0:QW];
  logic                      neg_r  [0:QW];
  logic                      sat_r  [0:QW];
  logic                      ov_r;
  tpcs_pkg::meta_t           om_r;
  logic [tpcs_pkg::YW-1:0]   y_r;

  logic [tpcs_pkg::NMW-1:0]  nmag;
  logic [tpcs_pkg::DMW-1:0]  dmag;
  logic [QW-1:0]             qf;
  logic [tpcs_pkg::YW-1:0]   yv;
  logic                      big;

  always_comb begin
    nmag = n_num[tpcs_pkg::NW-1] ? tpcs_pkg::NMW'(-n_num) : n_num[tpcs_pkg::NMW-1:0];
    dmag = n_den[tpcs_pkg::DENW-1] ? tpcs_pkg::DMW'(-n_den) : n_den[tpcs_pkg::DMW-1:0];
  end

  // prep stage: magnitudes, sign and the quotient overflow check
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= n_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]   <= n_meta;
      rem_r[0] <= nmag;
      dm_r[0]  <= dmag;
      q_r[0]   <= '0;
      neg_r[0] <= n_num[tpcs_pkg::NW-1] ^ n_den[tpcs_pkg::DENW-1];
      sat_r[0] <= ({3'b0, nmag} >= {dmag, {QW{1'b0}}});
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [tpcs_pkg::RW-1:0] trial;
    logic                    ge;
    assign trial = {{QW{1'b0}}, dm_r[j]} << K;
    assign ge    = ({3'b0, rem_r[j]} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j+1] <= 1'b0;
      else if (en) v_r[j+1] <= v_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j+1]   <= m_r[j];
        dm_r[j+1]  <= dm_r[j];
        neg_r[j+1] <= neg_r[j];
        sat_r[j+1] <= sat_r[j];
        rem_r[j+1] <= ge ? tpcs_pkg::NMW'({3'b0, rem_r[j]} - trial) : rem_r[j];
        q_r[j+1]   <= q_r[j] | (QW'(ge) << K);
      end
    end
  end

  always_comb begin
    qf  = q_r[QW];
    big = sat_r[QW] || (neg_r[QW] ? (qf > QW'(32768)) : (qf > QW'(32767)));
    if (big) yv = neg_r[QW] ? 16'h8000 : 16'h7fff;
    else     yv = neg_r[QW] ? -qf[tpcs_pkg::YW-1:0] : qf[tpcs_pkg::YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= m_r[QW];
      if (m_r[QW].fixed)      y_r <= m_r[QW].fix_y;
      else if (m_r[QW].degen) y_r <= '0;
      else                    y_r <= yv;
    end
  end

  assign o_valid = ov_r;
  assign o_meta  = om_r;
  assign o_y     = y_r;
endmodule

/* verif/tpcs_curve_checker.sv */
// Scoreboard for the three point curve sampler: predicts every curve sample
// from the accepted input words and compares the result words. Needs no package.
`timescale 1ns / 1ps
module tpcs_curve_checker #(
  parameter int NUM_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] in_start_x,
  input  logic [11:0] in_start_y,
  input  logic [11:0] in_mid_x,
  input  logic [11:0] in_mid_y,
  input  logic [11:0] in_target_x,
  input  logic [11:0] in_target_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_point_index,
  input  logic [11:0] out_point_x,
  input  logic [15:0] out_point_y,
  input  logic        out_degenerate,
  input  logic        out_last_point,
  output int          fail_count,
  output int          samples_pending
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [11:0] x;
    logic [15:0] y;
    logic        degen;
    logic        last;
  } curve_sample_t;

  curve_sample_t curve_samples[$];

  function automatic logic [15:0] clamp_y(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Exact rational Lagrange value, truncated toward zero.
  function automatic logic [15:0] parabola_y(longint x, longint x1, longint y1,
                                             longint x2, longint y2,
                                             longint x3, longint y3);
    longint d12, d13, d23, den, num;
    d12 = x1 - x2;
    d13 = x1 - x3;
    d23 = x2 - x3;
    den = d12 * d13 * d23;
    num = y1 * (x - x2) * (x - x3) * d23
        - y2 * (x - x1) * (x - x3) * d13
        + y3 * (x - x1) * (x - x2) * d12;
    if (den == 0) return '0;
    return clamp_y(num / den);
  endfunction

  task automatic queue_curve();
    longint sx, sy, mx, my, tx, ty, stride, x;
    logic flat;
    curve_sample_t s;
    sx = in_start_x;  sy = in_start_y;
    mx = in_mid_x;    my = in_mid_y;
    tx = in_target_x; ty = in_target_y;
    flat = (sx == mx) || (sx == tx) || (mx == tx);
    stride = (tx - sx) / longint'(NUM_POINTS - 1);
    curve_samples.push_back('{6'd0, sx[11:0], {4'd0, sy[11:0]}, 1'b0, 1'b0});
    for (int i = 1; i < NUM_POINTS - 1; i++) begin
      x = sx + longint'(i) * stride;
      s.idx   = i[5:0];
      s.x     = x[11:0];
      s.y     = flat ? 16'd0 : parabola_y(x, sx, sy, mx, my, tx, ty);
      s.degen = flat;
      s.last  = 1'b0;
      curve_samples.push_back(s);
    end
    s.idx = 6'(NUM_POINTS - 1);
    curve_samples.push_back('{s.idx, tx[11:0], {4'd0, ty[11:0]}, 1'b0, 1'b1});
  endtask

  always @(posedge clk) begin
    curve_sample_t want;
    int errs;
    if (!rst_n) begin
      curve_samples.delete();
      fail_count      <= 0;
      samples_pending <= 0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        if (curve_samples.size() == 0) begin
          errs++;
          $display("%0t: expected no word, got idx=%0d x=%0d y=%0d", $time,
                   out_point_index, out_point_x, $signed(out_point_y));
        end else begin
          want = curve_samples.pop_front();
          if (out_point_index !== want.idx) begin
            errs++;
            $display("%0t: point_index expected %0d got %0d", $time, want.idx,
                     out_point_index);
          end
          if (out_point_x !== want.x) begin
            errs++;
            $display("%0t: point_x idx %0d expected %0d got %0d", $time, want.idx,
                     want.x, out_point_x);
          end
          if (out_point_y !== want.y) begin
            errs++;
            $display("%0t: point_y idx %0d expected %0d got %0d", $time, want.idx,
                     $signed(want.y), $signed(out_point_y));
          end
          if (out_degenerate !== want.degen) begin
            errs++;
            $display("%0t: degenerate idx %0d expected %0b got %0b", $time,
                     want.idx, want.degen, out_degenerate);
          end
          if (out_last_point !== want.last) begin
            errs++;
            $display("%0t: last_point idx %0d expected %0b got %0b", $time,
                     want.idx, want.last, out_last_point);
          end
        end
      end
      if (in_valid && in_ready) queue_curve();
      fail_count      <= fail_count + errs;
      samples_pending <= curve_samples.size();
    end
  end

endmodule

/* verif/tb_three_point_curve_sampler_top.sv */
// Testbench top for the three point curve sampler: drives point words,
// stalls the result side and gives the verdict. Needs tpcs_curve_checker.
`timescale 1ns / 1ps
module tb_three_point_curve_sampler_top;

  localparam int NUM_POINTS  = 32;
  localparam int RANDOM_WORDS = 330;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_start_x = '0;
  logic [11:0] in_start_y = '0;
  logic [11:0] in_mid_x = '0;
  logic [11:0] in_mid_y = '0;
  logic [11:0] in_target_x = '0;
  logic [11:0] in_target_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_point_index;
  logic [11:0] out_point_x;
  logic [15:0] out_point_y;
  logic        out_degenerate;
  logic        out_last_point;
  int          fail_count;
  int          samples_pending;
  int          cycle_count = 0;

  three_point_curve_sampler_top #(.NUM_POINTS(NUM_POINTS)) uut (.*);
  tpcs_curve_checker #(.NUM_POINTS(NUM_POINTS)) checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: a while of normal pattern, one long hold-off so the setup
  // stages fill and in_ready falls, then a pattern that changes mode.
  initial begin
    int mode;
    @(posedge rst_n);
    repeat (300) begin
      @(posedge clk);
      out_ready <= ($urandom_range(3) != 0);
    end
    @(posedge clk);
    out_ready <= 1'b0;
    repeat (600) @(posedge clk);
    forever begin
      mode = $urandom_range(3);
      repeat ($urandom_range(80, 10)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          2: out_ready <= ($urandom_range(4) == 0);
          default: out_ready <= ($urandom_range(7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until it is taken. Valid is left high so a
  // following word in the same burst goes out with no bubble.
  task automatic send_word(input logic [11:0] sx, sy, mx, my, tx, ty);
    in_valid    <= 1'b1;
    in_start_x  <= sx;
    in_start_y  <= sy;
    in_mid_x    <= mx;
    in_mid_y    <= my;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Random word: mostly a well-formed curve with distinct x, sometimes
  // coincident x, sometimes tightly clustered x to drive y into saturation.
  task automatic send_random_word();
    logic [11:0] sx, mx, tx;
    int pick;
    pick = $urandom_range(9);
    sx = 12'($urandom_range(4095));
    mx = 12'($urandom_range(4095));
    tx = 12'($urandom_range(4095));
    if (pick == 0) mx = sx;
    else if (pick == 1) tx = sx;
    else if (pick == 2) tx = mx;
    else if (pick == 3) begin
      mx = sx + 12'($urandom_range(3) + 1);
      tx = mx + 12'($urandom_range(200) + 1);
    end
    send_word(sx, 12'($urandom_range(4095)), mx, 12'($urandom_range(4095)), tx,
              12'($urandom_range(4095)));
  endtask

  initial begin
    int sent;
    int burst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, each coincident-x case, descending x,
    // saturation both ways, tiny and full spans.
    send_word(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_word(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_word(12'd0, 12'hFFF, 12'd2048, 12'd0, 12'hFFF, 12'hFFF);
    send_word(12'hFFF, 12'd0, 12'd2048, 12'hFFF, 12'd0, 12'd0);
    send_word(12'd100, 12'd5, 12'd100, 12'd9, 12'd900, 12'd7);
    send_word(12'd100, 12'd5, 12'd700, 12'd9, 12'd100, 12'd7);
    send_word(12'd100, 12'd5, 12'd700, 12'd9, 12'd700, 12'd7);
    send_word(12'd0, 12'd0, 12'd1, 12'hFFF, 12'hFFF, 12'd0);
    send_word(12'd0, 12'hFFF, 12'd1, 12'd0, 12'hFFF, 12'hFFF);
    send_word(12'hFFF, 12'd0, 12'hFFE, 12'hFFF, 12'd0, 12'd0);
    idle_gap(5);
    send_word(12'd10, 12'd20, 12'd20, 12'd30, 12'd40, 12'd50);
    send_word(12'd10, 12'd20, 12'd15, 12'd30, 12'd30, 12'd40);
    send_word(12'd1000, 12'd1, 12'd1001, 12'd2, 12'd1002, 12'd3);
    send_word(12'd2000, 12'hAAA, 12'd1000, 12'h555, 12'd0, 12'hAAA);
    send_word(12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'h123, 12'hEDC);
    send_word(12'd0, 12'd4095, 12'd4094, 12'd0, 12'd4095, 12'd4095);
    send_word(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd1, 12'd0);
    send_word(12'd30, 12'd0, 12'd31, 12'd0, 12'd32, 12'd0);

    // Pause until the checker has nothing outstanding; let it count the last
    // accepted word at a clock edge before polling.
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 1);
      repeat (burst) begin
        send_random_word();
        sent++;
      end
      idle_gap(($urandom_range(3) == 0) ? 0 : $urandom_range(70));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (samples_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
